// ===== rtl/core/mep_pkg.sv =====
// mep_pkg: shared types, constants and the blue color table for the escape-time pixel core
// no dependencies; imported by every other file of the block

package mep_pkg;

	// field widths
	localparam int PIX_W = 12;
	localparam int CNT_W = 8;
	localparam int COLOR_W = 24;
	localparam int REG_W = 32;
	localparam int MUL_W = 33;
	localparam int PROD_W = 64;
	localparam int SUM_W = 65;

	// parameter defaults
	localparam int MAX_ITER_DEF = 255;
	localparam int FRAC_BITS_DEF = 26;
	localparam int COORD_BITS_DEF = 12;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_START = 2'd0,
		REG_Y_START = 2'd1,
		REG_X_STEP  = 2'd2,
		REG_Y_STEP  = 2'd3
	} cfg_index_t;

	// register reset values
	localparam logic signed [REG_W-1:0] X_START_RST = -32'sd134217728;
	localparam logic signed [REG_W-1:0] Y_START_RST = -32'sd100663296;
	localparam logic signed [REG_W-1:0] X_STEP_RST = 32'sd314573;
	localparam logic signed [REG_W-1:0] Y_STEP_RST = 32'sd419430;

	// green channel nibble masks
	localparam logic [CNT_W-1:0] NIB_LO = 8'h0f;
	localparam logic [CNT_W-1:0] NIB_HI = 8'hf0;

	typedef struct packed {
		logic signed [REG_W-1:0] x_start;
		logic signed [REG_W-1:0] y_start;
		logic signed [REG_W-1:0] x_step;
		logic signed [REG_W-1:0] y_step;
	} cfg_t;

	// control from the top level to the iteration engine
	typedef struct packed {
		logic start;
		logic take;
	} iter_ctl_t;

	// status from the iteration engine
	typedef struct packed {
		logic             idle;
		logic             done;
		logic [CNT_W-1:0] count;
	} iter_sts_t;

	// clamp a wide sum into the signed 32-bit range
	function automatic logic signed [REG_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [REG_W-1:0] r;
		if (!v[SUM_W-1] && (|v[SUM_W-2:REG_W-1])) begin
			r = {1'b0, {(REG_W-1){1'b1}}};
		end else if (v[SUM_W-1] && !(&v[SUM_W-2:REG_W-1])) begin
			r = {1'b1, {(REG_W-1){1'b0}}};
		end else begin
			r = v[REG_W-1:0];
		end
		return r;
	endfunction

	// blue table: floor(127 + 127*sin(n/255)) by a fixed-point series, built at elaboration
	localparam int SIN_SCALE_BITS = 47;
	localparam int SERIES_TERMS = 12;
	localparam int ROM_DEPTH = 256;
	localparam logic [63:0] BLUE_DEN = 64'd255;
	localparam logic [63:0] BLUE_AMP = 64'd127;
	localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	typedef logic [CNT_W-1:0] blue_rom_t [ROM_DEPTH];

	function automatic logic [CNT_W-1:0] blue_of(input logic [CNT_W-1:0] n);
		logic [63:0] nn;
		logic [63:0] t;
		logic [63:0] sum;
		logic [63:0] res;
		nn = 64'(n);
		t = ((BLUE_AMP * nn) << SIN_SCALE_BITS) / BLUE_DEN;
		sum = t;
		for (int k = 0; k < SERIES_TERMS; k++) begin
			t = t * nn / BLUE_DEN;
			t = t * nn / BLUE_DEN;
			t = t / SERIES_DIV[k];
			if (k % 2 == 1) sum = sum + t;
			else sum = sum - t;
		end
		res = BLUE_AMP + (sum >> SIN_SCALE_BITS);
		return res[CNT_W-1:0];
	endfunction

	function automatic blue_rom_t build_blue_rom();
		blue_rom_t r;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			r[i] = blue_of(CNT_W'(i));
		end
		return r;
	endfunction

	localparam blue_rom_t BLUE_ROM = build_blue_rom();

endpackage

// ===== rtl/core/mep_pixel_if.sv =====
// mep_pixel_if: input channel carrying one pixel coordinate pair per beat
// depends on mep_pkg for field widths

interface mep_pixel_if import mep_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_column;
	logic [PIX_W-1:0] pixel_row;

	modport source (output valid, output pixel_column, output pixel_row, input ready);
	modport sink (input valid, input pixel_column, input pixel_row, output ready);
endinterface

// ===== rtl/core/mep_result_if.sv =====
// mep_result_if: output channel carrying one color and escape count per beat
// depends on mep_pkg for field widths

interface mep_result_if import mep_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] pixel_color;
	logic [CNT_W-1:0]   escape_count;

	modport source (output valid, output pixel_color, output escape_count, input ready);
	modport sink (input valid, input pixel_color, input escape_count, output ready);
endinterface

// ===== rtl/core/mandelbrot_escape_pixel_core.sv =====
// mandelbrot_escape_pixel_core: escape-time pixel, one pixel in flight at a time.
// the escape count is at most MAX_ITER; the shared multiplier forms x*x, y*y and x*y
// in turn for each iteration; a finished result waits in the output register while
// the next pixel is taken.
// reset: configuration registers return to their defaults, sequencer idle, no result pending.

module mandelbrot_escape_pixel_core import mep_pkg::*; #(
	parameter int MAX_ITER   = MAX_ITER_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0]     wr_data,
	mep_pixel_if.sink            pix,
	mep_result_if.source         res
);

	cfg_t cfg_q;
	iter_ctl_t ctl;
	iter_sts_t sts;

	logic out_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic [CNT_W-1:0] count_q;

	logic [CNT_W-1:0] green;
	logic [COLOR_W-1:0] color;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_start <= X_START_RST;
			cfg_q.y_start <= Y_START_RST;
			cfg_q.x_step <= X_STEP_RST;
			cfg_q.y_step <= Y_STEP_RST;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				REG_X_START: cfg_q.x_start <= wr_data;
				REG_Y_START: cfg_q.y_start <= wr_data;
				REG_X_STEP:  cfg_q.x_step <= wr_data;
				REG_Y_STEP:  cfg_q.y_step <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// handshake to the engine
	assign pix.ready = sts.idle;
	assign ctl.start = pix.valid && sts.idle;
	assign ctl.take = sts.done && (!out_valid_q || res.ready);

	mep_iter #(
		.MAX_ITER   (MAX_ITER),
		.FRAC_BITS  (FRAC_BITS),
		.COORD_BITS (COORD_BITS)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.col_in (pix.pixel_column),
		.row_in (pix.pixel_row),
		.ctl    (ctl),
		.sts    (sts)
	);

	// color: black when never escaped, else count / swapped nibbles / blue table
	assign green = ((sts.count & NIB_LO) << 4) | ((sts.count & NIB_HI) >> 4);
	assign color = (sts.count == CNT_W'(MAX_ITER)) ? '0
		: {sts.count, green, BLUE_ROM[sts.count]};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			color_q <= color;
			count_q <= sts.count;
		end
	end

	assign res.valid = out_valid_q;
	assign res.pixel_color = color_q;
	assign res.escape_count = count_q;

endmodule

// ===== rtl/core/mep_mul.sv =====
// mep_mul: shared signed 33x33 multiplier with a registered product
// depends on mep_pkg for operand and product widths

module mep_mul import mep_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p_q
);

	logic signed [2*MUL_W-1:0] prod;

	// full product, low 64 bits hold every value the sequencer asks for
	assign prod = a * b;

	always_ff @(posedge clk) begin
		p_q <= prod[PROD_W-1:0];
	end

endmodule

// ===== rtl/core/mep_iter.sv =====
// mep_iter: sequencer and datapath for one pixel, forms c and iterates z = z*z + c
// depends on mep_pkg and mep_mul

module mep_iter import mep_pkg::*; #(
	parameter int MAX_ITER   = MAX_ITER_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic [PIX_W-1:0] col_in,
	input  logic [PIX_W-1:0] row_in,
	input  iter_ctl_t        ctl,
	output iter_sts_t        sts
);

	localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);
	localparam logic [CNT_W-1:0] ITER_LIMIT = CNT_W'(MAX_ITER);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MCR  = 8'b0000_0010,
		ST_MCI  = 8'b0000_0100,
		ST_MXX  = 8'b0000_1000,
		ST_MYY  = 8'b0001_0000,
		ST_MXY  = 8'b0010_0000,
		ST_UPD  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic signed [REG_W-1:0] cr_q;
	logic signed [REG_W-1:0] ci_q;
	logic signed [REG_W-1:0] x_q;
	logic signed [REG_W-1:0] y_q;
	logic signed [REG_W-1:0] nx_q;
	logic signed [PROD_W-1:0] xx_q;
	logic [CNT_W-1:0] n_q;

	logic [PIX_W+COORD_BITS-1:0] col_ext;
	logic [PIX_W+COORD_BITS-1:0] row_ext;
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [PROD_W-1:0] p_q;

	logic [PROD_W-1:0] mag2;
	logic escape;
	logic signed [PROD_W-1:0] diff;
	logic signed [PROD_W-1:0] diff_sh;
	logic signed [PROD_W-1:0] xy_sh;
	logic signed [SUM_W-1:0] cr_sum;
	logic signed [SUM_W-1:0] ci_sum;
	logic signed [SUM_W-1:0] nx_sum;
	logic signed [SUM_W-1:0] ny_sum;

	// keep the low COORD_BITS of each pixel index
	assign col_ext = {{COORD_BITS{1'b0}}, col_in};
	assign row_ext = {{COORD_BITS{1'b0}}, row_in};

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MCR: begin
				mul_a = {cfg.x_step[REG_W-1], cfg.x_step};
				mul_b = MUL_W'(col_q);
			end
			ST_MCI: begin
				mul_a = {cfg.y_step[REG_W-1], cfg.y_step};
				mul_b = MUL_W'(row_q);
			end
			ST_MXX: begin
				mul_a = {x_q[REG_W-1], x_q};
				mul_b = {x_q[REG_W-1], x_q};
			end
			ST_MYY: begin
				mul_a = {y_q[REG_W-1], y_q};
				mul_b = {y_q[REG_W-1], y_q};
			end
			ST_MXY: begin
				mul_a = {x_q[REG_W-1], x_q};
				mul_b = {y_q[REG_W-1], y_q};
			end
			ST_UPD: begin
				mul_a = {nx_q[REG_W-1], nx_q};
				mul_b = {nx_q[REG_W-1], nx_q};
			end
			ST_IDLE, ST_DONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	mep_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// c from start plus step times index
	assign cr_sum = {p_q[PROD_W-1], p_q} + SUM_W'(cfg.x_start);
	assign ci_sum = {p_q[PROD_W-1], p_q} + SUM_W'(cfg.y_start);

	// escape test, p_q holds y*y in ST_MXY
	assign mag2 = xx_q + p_q;
	assign escape = (mag2 >= ESC_LIMIT) || (n_q >= ITER_LIMIT);

	// next real part, p_q holds y*y
	assign diff = xx_q - p_q;
	assign diff_sh = diff >>> FRAC_BITS;
	assign nx_sum = {diff_sh[PROD_W-1], diff_sh} + SUM_W'(cr_q);

	// next imaginary part, p_q holds x*y in ST_UPD
	assign xy_sh = p_q >>> (FRAC_BITS - 1);
	assign ny_sum = {xy_sh[PROD_W-1], xy_sh} + SUM_W'(ci_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (ctl.start) state_q <= ST_MCR;
				ST_MCR:  state_q <= ST_MCI;
				ST_MCI:  state_q <= ST_MXX;
				ST_MXX:  state_q <= ST_MYY;
				ST_MYY:  state_q <= ST_MXY;
				ST_MXY:  state_q <= escape ? ST_DONE : ST_UPD;
				ST_UPD:  state_q <= ST_MYY;
				ST_DONE: if (ctl.take) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					col_q <= col_ext[COORD_BITS-1:0];
					row_q <= row_ext[COORD_BITS-1:0];
				end
			end
			ST_MCI: begin
				cr_q <= sat32(cr_sum);
				x_q <= '0;
				y_q <= '0;
				n_q <= '0;
			end
			ST_MXX: ci_q <= sat32(ci_sum);
			ST_MYY: xx_q <= p_q;
			ST_MXY: nx_q <= sat32(nx_sum);
			ST_UPD: begin
				x_q <= nx_q;
				y_q <= sat32(ny_sum);
				n_q <= n_q + 1'b1;
			end
			ST_MCR, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign sts.idle = (state_q == ST_IDLE);
	assign sts.done = (state_q == ST_DONE);
	assign sts.count = n_q;

endmodule

// ===== dv/mep_escape_checker.sv =====
`timescale 1ns / 1ps
// mep_escape_checker: follows the register port and both channels of the escape-time core,
// predicts every result beat from its own fixed-point iteration and compares field by field
// depends on mep_pkg, mep_pixel_if and mep_result_if

module mep_escape_checker import mep_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0]     wr_data,
	mep_pixel_if                 pix,
	mep_result_if                res,
	output int                   errors,
	output int                   outstanding
);

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [CNT_W-1:0]   count;
	} pixel_result_t;

	localparam longint unsigned ESCAPE_RADIUS_SQ = 64'd4 << (2 * FRAC_BITS_DEF);
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam int SINE_FRAC_BITS = 47;
	localparam int SINE_TERMS = 12;

	// shadow copy of the view registers
	longint view_x0;
	longint view_y0;
	longint view_dx;
	longint view_dy;

	// predicted results, oldest first
	pixel_result_t predicted_pixels[$];

	function automatic longint clamp32(input longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	// floor(127 + 127*sin(n/255)) through an integer taylor series
	function automatic logic [CNT_W-1:0] sine_blue(input logic [CNT_W-1:0] n);
		longint unsigned nn;
		longint unsigned term;
		longint unsigned acc;
		longint unsigned full;
		nn = n;
		term = ((64'd127 * nn) << SINE_FRAC_BITS) / 64'd255;
		acc = term;
		for (int k = 0; k < SINE_TERMS; k++) begin
			term = term * nn / 64'd255;
			term = term * nn / 64'd255;
			term = term / ((2 * k + 2) * (2 * k + 3));
			if (k % 2 == 1) acc = acc + term;
			else acc = acc - term;
		end
		full = 64'd127 + (acc >> SINE_FRAC_BITS);
		return full[CNT_W-1:0];
	endfunction

	// escape count and color of one pixel under the current view
	function automatic pixel_result_t escape_time(input logic [PIX_W-1:0] col,
	                                              input logic [PIX_W-1:0] row);
		longint cr;
		longint ci;
		longint x;
		longint y;
		longint nx;
		longint ny;
		longint unsigned mag;
		int unsigned iter;
		logic [CNT_W-1:0] n;
		pixel_result_t r;
		cr = clamp32(view_x0 + view_dx * longint'(col));
		ci = clamp32(view_y0 + view_dy * longint'(row));
		x = 0;
		y = 0;
		iter = 0;
		mag = 0;
		while (mag < ESCAPE_RADIUS_SQ && iter < MAX_ITER_DEF) begin
			nx = clamp32(((x * x - y * y) >>> FRAC_BITS_DEF) + cr);
			ny = clamp32(((x * y) >>> (FRAC_BITS_DEF - 1)) + ci);
			x = nx;
			y = ny;
			iter++;
			// squares stay full width, the sum is compared unsigned
			mag = x * x + y * y;
		end
		n = iter[CNT_W-1:0];
		r.count = n;
		if (iter == MAX_ITER_DEF) r.color = '0;
		else r.color = {n, n[3:0], n[7:4], sine_blue(n)};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			view_x0 = X_START_RST;
			view_y0 = Y_START_RST;
			view_dx = X_STEP_RST;
			view_dy = Y_STEP_RST;
			predicted_pixels.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			// register writes
			if (wr_en) begin
				case (cfg_index_t'(wr_index))
					REG_X_START: view_x0 = longint'(signed'(wr_data));
					REG_Y_START: view_y0 = longint'(signed'(wr_data));
					REG_X_STEP:  view_dx = longint'(signed'(wr_data));
					REG_Y_STEP:  view_dy = longint'(signed'(wr_data));
					default: ;
				endcase
			end

			// result beat against the oldest prediction
			if (res.valid && res.ready) begin
				if (predicted_pixels.size() == 0) begin
					$error("result beat with no pixel pending: pixel_color %h, escape_count %0d",
						res.pixel_color, res.escape_count);
					errors++;
				end else begin
					want = predicted_pixels.pop_front();
					if (res.pixel_color !== want.color) begin
						$error("pixel_color: expected %h, actual %h", want.color, res.pixel_color);
						errors++;
					end
					if (res.escape_count !== want.count) begin
						$error("escape_count: expected %0d, actual %0d", want.count,
							res.escape_count);
						errors++;
					end
				end
			end

			// pixel beat
			if (pix.valid && pix.ready) begin
				predicted_pixels.push_back(escape_time(pix.pixel_column, pix.pixel_row));
			end

			outstanding <= predicted_pixels.size();
		end
	end

endmodule

// ===== dv/mandelbrot_escape_pixel_core_tb.sv =====
`timescale 1ns / 1ps
// mandelbrot_escape_pixel_core_tb: clock, reset, view register writes and pixel traffic with
// random idling on both channels; mep_escape_checker predicts and compares the results
// depends on mep_pkg, mep_pixel_if, mep_result_if, mep_escape_checker and the core

module mandelbrot_escape_pixel_core_tb;
	import mep_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int BATCHES = 12;
	localparam int BATCH_PIXELS = 70;
	localparam int MAX_PIXELS = 900;
	localparam int PIXEL_CYCLES = 3 * MAX_ITER_DEF + 7;
	localparam int CYCLE_LIMIT = 4 * MAX_PIXELS * (PIXEL_CYCLES + 64);
	localparam int SETTLE_CYCLES = PIXEL_CYCLES + 16;
	localparam int Q_ONE = 1 << FRAC_BITS_DEF;
	localparam logic [REG_W-1:0] Q_MAX_BITS = 32'h7fff_ffff;
	localparam logic [REG_W-1:0] Q_MIN_BITS = 32'h8000_0000;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [REG_W-1:0] wr_data;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int cycle_count = 0;
	int errors;
	int outstanding;

	mep_pixel_if  pix_ch ();
	mep_result_if res_ch ();

	mandelbrot_escape_pixel_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pix      (pix_ch),
		.res      (res_ch)
	);

	mep_escape_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.pix         (pix_ch),
		.res         (res_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	task automatic write_reg(input cfg_index_t idx, input logic [REG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	// all four view registers back to back; block must be idle
	task automatic set_view(input logic [REG_W-1:0] xs, input logic [REG_W-1:0] ys,
	                        input logic [REG_W-1:0] dx, input logic [REG_W-1:0] dy);
		write_reg(REG_X_START, xs);
		write_reg(REG_Y_START, ys);
		write_reg(REG_X_STEP, dx);
		write_reg(REG_Y_STEP, dy);
		wr_en <= 1'b0;
	endtask

	// one pixel beat, with random idle cycles ahead of it
	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_column <= col;
		pix_ch.pixel_row <= row;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
	endtask

	// drop valid and wait for every predicted result to arrive
	task automatic wait_idle();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		logic [REG_W-1:0] xs;
		logic [REG_W-1:0] ys;
		logic [REG_W-1:0] dx;
		logic [REG_W-1:0] dy;
		int step;
		wr_en <= 1'b0;
		wr_index <= REG_X_START;
		wr_data <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.pixel_column <= '0;
		pix_ch.pixel_row <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: corners, a point inside the main cardioid, slow points near the edge
		send_pixel(12'd0, 12'd0);
		send_pixel(PIX_MAX, PIX_MAX);
		send_pixel(12'd0, PIX_MAX);
		send_pixel(PIX_MAX, 12'd0);
		send_pixel(12'd400, 12'd240);
		send_pixel(12'd480, 12'd240);
		send_pixel(12'd300, 12'd100);
		wait_idle();

		// every point at the origin: never escapes, black
		set_view('0, '0, '0, '0);
		send_pixel(12'd0, 12'd0);
		send_pixel(PIX_MAX, 12'h555);
		wait_idle();

		// c saturating at both rails
		set_view(Q_MAX_BITS, Q_MIN_BITS, Q_MAX_BITS, Q_MIN_BITS);
		send_pixel(PIX_MAX, PIX_MAX);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
		wait_idle();

		// both components on the negative rail: largest squared magnitude
		set_view(Q_MIN_BITS, Q_MIN_BITS, '0, '0);
		send_pixel(12'haaa, 12'h555);
		wait_idle();

		// negative steps walking back from the positive rail
		set_view(Q_MAX_BITS, Q_MAX_BITS, Q_MIN_BITS, Q_MIN_BITS);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd2, 12'd0);
		send_pixel(12'd0, 12'd2);
		wait_idle();

		// slow escapes near the cusp and the neck of the period-two bulb
		set_view(Q_ONE / 4 + Q_ONE / 256, 0, Q_ONE / 4096, Q_ONE / 4096);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd3, 12'd5);
		wait_idle();
		set_view(-3 * Q_ONE / 4, Q_ONE / 64, Q_ONE / 8192, Q_ONE / 8192);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd7, 12'd2);
		wait_idle();

		// random views and pixels, one idling pattern per batch
		for (int b = 0; b < BATCHES; b++) begin
			case ($urandom_range(0, 9))
				0: begin
					xs = $urandom();
					ys = $urandom();
					dx = $urandom();
					dy = $urandom();
				end
				1: begin
					xs = $urandom_range(0, 1) ? Q_MAX_BITS : Q_MIN_BITS;
					ys = $urandom_range(0, 1) ? Q_MAX_BITS : Q_MIN_BITS;
					dx = $urandom_range(0, 1) ? Q_MAX_BITS : Q_MIN_BITS;
					dy = $urandom_range(0, 1) ? Q_MAX_BITS : Q_MIN_BITS;
				end
				default: begin
					// window of about 128 pixels around the set, -2.1..0.3 by -1.2..0.9
					xs = -140928614 + $urandom_range(0, 161061273);
					ys = -80530637 + $urandom_range(0, 140928614);
					step = $urandom_range(33554, 671089);
					dx = ($urandom_range(0, 3) != 0) ? step : -step;
					step = $urandom_range(33554, 671089);
					dy = ($urandom_range(0, 3) != 0) ? step : -step;
				end
			endcase
			set_view(xs, ys, dx, dy);

			case (b % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 66;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 66;
				end
				default: begin
					src_idle_pct = 14;
					sink_stall_pct = 14;
				end
			endcase

			for (int i = 0; i < BATCH_PIXELS; i++) begin
				if ($urandom_range(0, 99) < 85) begin
					send_pixel(PIX_W'($urandom_range(0, 127)),
						PIX_W'($urandom_range(0, 127)));
				end else begin
					send_pixel(PIX_W'($urandom_range(0, PIX_MAX)),
						PIX_W'($urandom_range(0, PIX_MAX)));
				end
			end
			wait_idle();
		end

		// let any stray result beat show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
